FILE: sv/lrcf_pkg.sv
package lrcf_pkg;

  // Coordinate width of every point and box field
  localparam int COORD_BITS = 14;

  localparam int CW = COORD_BITS;    // coordinate
  localparam int EW = CW + 1;        // box edge, widened band edge, signed difference
  localparam int NW = CW + 2;        // signed step along the primary axis
  localparam int HW = 9;             // half thickness plus kill zone
  localparam int XW = CW + 3;        // corner offset from a shifted line origin
  localparam int VW = XW + EW + 1;   // cross product of the side test
  localparam int PW = EW + NW;       // signed slope numerator
  localparam int QW = PW - 1;        // numerator magnitude, quotient
  localparam int SW = 2 * CW + 4;    // clipped band edge before clamping
  localparam int LW = 2 * EW + 2;    // clipped band area
  localparam int TW = LW + 8;        // area compare

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_KILL_ZONE = 2'd0,
    REG_KILL_RATE = 2'd1,
    REG_KILL_MODE = 2'd2
  } reg_idx_e;

  // Kill mode codes; the spare code behaves as the confirmed-only mode
  localparam logic [1:0] MODE_MARK      = 2'd0;
  localparam logic [1:0] MODE_CONFIRMED = 2'd1;
  localparam logic [1:0] MODE_ALL       = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic                 overlap;
    logic                 removable;
    logic                 axis;
    logic                 steep;
    logic                 den_zero;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;
    logic signed [EW-1:0] dx;
    logic signed [EW-1:0] dy;
    logic [HW-1:0]        half;
    logic [EW-1:0]        r0;
    logic [EW-1:0]        r1;
    logic [EW-1:0]        r2;
    logic [EW-1:0]        r3;
    logic [CW-1:0]        bw;
    logic [CW-1:0]        bh;
    logic signed [EW-1:0] dp;
    logic signed [EW-1:0] dq;
    logic signed [NW-1:0] na;
    logic signed [NW-1:0] nb;
    logic [CW-1:0]        qa;
    logic [EW-1:0]        qlo;
    logic [EW-1:0]        qhi;
    logic [EW-1:0]        s_lo;
    logic [EW-1:0]        s_hi;
  } item_t;

  function automatic logic in_span(input logic [EW-1:0] v, input logic [EW-1:0] lo,
                                   input logic [EW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // Edges of either rectangle within the spans of the other, laid out l, t, r, b
  function automatic logic rects_meet(input logic [EW-1:0] a0, input logic [EW-1:0] a1,
                                      input logic [EW-1:0] a2, input logic [EW-1:0] a3,
                                      input logic [EW-1:0] b0, input logic [EW-1:0] b1,
                                      input logic [EW-1:0] b2, input logic [EW-1:0] b3);
    logic [EW-1:0] aly, ahy, alx, ahx, bly, bhy, blx, bhx;
    logic          hit;
    aly = (a1 < a3) ? a1 : a3;
    ahy = (a1 > a3) ? a1 : a3;
    alx = (a0 < a2) ? a0 : a2;
    ahx = (a0 > a2) ? a0 : a2;
    bly = (b1 < b3) ? b1 : b3;
    bhy = (b1 > b3) ? b1 : b3;
    blx = (b0 < b2) ? b0 : b2;
    bhx = (b0 > b2) ? b0 : b2;
    hit = ((in_span(b1, aly, ahy) || in_span(b3, aly, ahy)) &&
           (in_span(b0, alx, ahx) || in_span(b2, alx, ahx))) ||
          ((in_span(a1, bly, bhy) || in_span(a3, bly, bhy)) &&
           (in_span(a0, blx, bhx) || in_span(a2, blx, bhx)));
    return hit;
  endfunction

endpackage

FILE: sv/line_residue_component_filter.sv
// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  line end points, thickness, confirmed, box
// out      out_valid_o/out_stall_i  box_overlaps, is_residue, remove_box
// cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle sustained while the output is not stalled; out_valid_o rises
// after stage 1, the bit-per-stage slope dividers and back stages 3 to 6.
// Reset clears the configuration registers, the queue and all stage valids.
// An output stall while out_valid_o is high freezes the back pipeline; the two-entry
// queue keeps taking requests until it fills, then in_stall_o rises.
module line_residue_component_filter import lrcf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [CW-1:0] line_start_x_i,
  input  logic [CW-1:0] line_start_y_i,
  input  logic [CW-1:0] line_end_x_i,
  input  logic [CW-1:0] line_end_y_i,
  input  logic [7:0]    line_thickness_i,
  input  logic          line_confirmed_i,
  input  logic [CW-1:0] box_left_i,
  input  logic [CW-1:0] box_top_i,
  input  logic [CW-1:0] box_width_i,
  input  logic [CW-1:0] box_height_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          box_overlaps_o,
  output logic          is_residue_o,
  output logic          remove_box_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  logic [7:0] kill_zone_q, kill_rate_q;
  logic [1:0] kill_mode_q;
  item_t      fr_item, q_item;
  logic       q_full, q_valid, q_pop, push;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_zone_q <= '0;
      kill_rate_q <= '0;
      kill_mode_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_KILL_ZONE: kill_zone_q <= cfg_data_i;
        REG_KILL_RATE: kill_rate_q <= cfg_data_i;
        REG_KILL_MODE: kill_mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign push       = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  lrcf_front u_front (
    .line_start_x_i   (line_start_x_i),
    .line_start_y_i   (line_start_y_i),
    .line_end_x_i     (line_end_x_i),
    .line_end_y_i     (line_end_y_i),
    .line_thickness_i (line_thickness_i),
    .line_confirmed_i (line_confirmed_i),
    .box_left_i       (box_left_i),
    .box_top_i        (box_top_i),
    .box_width_i      (box_width_i),
    .box_height_i     (box_height_i),
    .kill_zone_i      (kill_zone_q),
    .kill_mode_i      (kill_mode_q),
    .item_o           (fr_item)
  );

  lrcf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  lrcf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .pop_o          (q_pop),
    .kill_rate_i    (kill_rate_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .box_overlaps_o (box_overlaps_o),
    .is_residue_o   (is_residue_o),
    .remove_box_o   (remove_box_o)
  );

endmodule

FILE: sv/lrcf_front.sv
module lrcf_front import lrcf_pkg::*; (
  input  logic [CW-1:0] line_start_x_i,
  input  logic [CW-1:0] line_start_y_i,
  input  logic [CW-1:0] line_end_x_i,
  input  logic [CW-1:0] line_end_y_i,
  input  logic [7:0]    line_thickness_i,
  input  logic          line_confirmed_i,
  input  logic [CW-1:0] box_left_i,
  input  logic [CW-1:0] box_top_i,
  input  logic [CW-1:0] box_width_i,
  input  logic [CW-1:0] box_height_i,
  input  logic [7:0]    kill_zone_i,
  input  logic [1:0]    kill_mode_i,
  output item_t         item_o
);

  logic [HW-1:0]        grow, half;
  logic [EW-1:0]        ax_e, ay_e, bx_e, by_e, g_e, kz_e;
  logic [EW-1:0]        r0, r1, r2, r3, b0, b1, b2, b3;
  logic signed [EW-1:0] dx, dy, dp, dq;
  logic [EW-1:0]        adx, ady;
  logic                 steep;
  logic [EW-1:0]        pa, pb, plo, phi, qlo, qhi, s_lo, s_hi, t_hi;
  logic [CW-1:0]        qa;
  logic signed [NW-1:0] t_lo, plo_n, s_lo_n;

  // Widening margins and box corners
  always_comb begin
    grow = HW'(line_thickness_i[7:1]) + HW'(kill_zone_i);
    half = HW'(({1'b0, line_thickness_i} + 9'd1) >> 1) + HW'(kill_zone_i);
    ax_e = EW'(line_start_x_i);
    ay_e = EW'(line_start_y_i);
    bx_e = EW'(line_end_x_i);
    by_e = EW'(line_end_y_i);
    g_e  = EW'(grow);
    kz_e = EW'(kill_zone_i);
    r0   = EW'(box_left_i);
    r1   = EW'(box_top_i);
    r2   = EW'(box_left_i) + EW'(box_width_i);
    r3   = EW'(box_top_i) + EW'(box_height_i);
  end

  // Line rectangle widened on every side, clamped at zero
  always_comb begin
    if (ax_e <= bx_e) begin
      b0 = (ax_e < g_e) ? '0 : ax_e - g_e;
      b2 = bx_e + g_e;
    end else begin
      b0 = ax_e + g_e;
      b2 = (bx_e < g_e) ? '0 : bx_e - g_e;
    end
    if (by_e <= ay_e) begin
      b3 = (by_e < g_e) ? '0 : by_e - g_e;
      b1 = ay_e + g_e;
    end else begin
      b3 = by_e + g_e;
      b1 = (ay_e < g_e) ? '0 : ay_e - g_e;
    end
  end

  // Direction and choice of primary axis for the area test
  always_comb begin
    dx    = signed'(ax_e - bx_e);
    dy    = signed'(ay_e - by_e);
    adx   = dx[EW-1] ? EW'(-dx) : EW'(dx);
    ady   = dy[EW-1] ? EW'(-dy) : EW'(dy);
    steep = adx < ady;
    if (!steep) begin
      pa = ax_e; pb = bx_e; qa = line_start_y_i; dp = dx; dq = dy;
      plo = r0; phi = r2; qlo = r1; qhi = r3;
    end else begin
      pa = ay_e; pb = by_e; qa = line_start_x_i; dp = dy; dq = dx;
      plo = r1; phi = r3; qlo = r0; qhi = r2;
    end
  end

  // Primary span clipped to the box, and steps from the start point
  always_comb begin
    t_lo   = signed'(NW'(pa)) - signed'(NW'(kz_e));
    plo_n  = signed'(NW'(plo));
    s_lo_n = (t_lo <= plo_n) ? plo_n : t_lo;
    s_lo   = EW'(s_lo_n);
    t_hi   = pb + kz_e;
    s_hi   = (t_hi >= phi) ? phi : t_hi;
    if (s_hi <= s_lo) begin
      s_hi = s_lo;
    end
  end

  always_comb begin
    item_o.overlap   = rects_meet(b0, b1, b2, b3, r0, r1, r2, r3);
    item_o.removable = (kill_mode_i == MODE_ALL) ||
                       ((kill_mode_i != MODE_MARK) && line_confirmed_i);
    item_o.axis      = (ax_e == bx_e) || (ay_e == by_e);
    item_o.steep     = steep;
    item_o.den_zero  = (dp == '0);
    item_o.ax        = line_start_x_i;
    item_o.ay        = line_start_y_i;
    item_o.dx        = dx;
    item_o.dy        = dy;
    item_o.half      = half;
    item_o.r0        = r0;
    item_o.r1        = r1;
    item_o.r2        = r2;
    item_o.r3        = r3;
    item_o.bw        = box_width_i;
    item_o.bh        = box_height_i;
    item_o.dp        = dp;
    item_o.dq        = dq;
    item_o.na        = signed'(NW'(pa)) - signed'(NW'(s_lo));
    item_o.nb        = signed'(NW'(pa)) - signed'(NW'(s_hi));
    item_o.qa        = qa;
    item_o.qlo       = qlo;
    item_o.qhi       = qhi;
    item_o.s_lo      = s_lo;
    item_o.s_hi      = s_hi;
  end

endmodule

FILE: sv/lrcf_fifo.sv
module lrcf_fifo import lrcf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

FILE: sv/lrcf_div.sv
module lrcf_div import lrcf_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] num_i,
  input  logic [CW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  // One quotient bit per stage, most significant first
  logic [CW-1:0] rem_q [QW];
  logic [CW-1:0] den_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [CW-1:0] rem_d [QW];
  logic [QW-1:0] num_d [QW];
  logic [QW-1:0] quo_d [QW];
  logic [CW-1:0] den_d [QW];

  always_comb begin
    logic [CW-1:0] rem_in;
    logic [QW-1:0] num_in, quo_in;
    logic [CW:0]   trial;
    for (int k = 0; k < QW; k++) begin
      rem_in   = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k - 1];
      num_in   = (k == 0) ? num_i : num_q[(k == 0) ? 0 : k - 1];
      quo_in   = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k - 1];
      den_d[k] = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k - 1];
      trial    = {rem_in, num_in[QW-1]};
      if (trial >= {1'b0, den_d[k]}) begin
        rem_d[k] = CW'(trial - {1'b0, den_d[k]});
        quo_d[k] = {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_d[k] = CW'(trial);
        quo_d[k] = {quo_in[QW-2:0], 1'b0};
      end
      num_d[k] = {num_in[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= num_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

FILE: sv/lrcf_back.sv
module lrcf_back import lrcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       pop_o,
  input  logic [7:0] kill_rate_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       box_overlaps_o,
  output logic       is_residue_o,
  output logic       remove_box_o
);

  typedef struct packed {
    logic              overlap;
    logic              removable;
    logic              axis;
    logic              den_zero;
    logic              side_ok;
    logic              sgn_a;
    logic              sgn_b;
    logic [CW-1:0]     qa;
    logic [HW-1:0]     half;
    logic [EW-1:0]     qlo;
    logic [EW-1:0]     qhi;
    logic [EW-1:0]     s_lo;
    logic [EW-1:0]     s_hi;
    logic [2*EW-1:0]   srect;
  } car_t;

  logic                 en;
  // stage 1: side products and slope numerators
  logic                 v1_q;
  car_t                 c1_d, c1_q;
  logic [7:0]           zf_d, pf_d, zf_q, pf_q;
  logic signed [PW-1:0] na_d, nb_d, na_q, nb_q;
  logic [CW-1:0]        dm_d, dm_q;
  logic                 dn_d, dn_q;
  // stage 2: into the dividers
  car_t                 c2;
  logic [QW-1:0]        mag_a, mag_b, quo_a, quo_b;
  logic                 any_pos, any_neg;
  logic                 dv_q [QW];
  car_t                 dc_q [QW];
  // stage 3 to 6
  logic                 v3_q, v4_q, v5_q, v6_q;
  car_t                 c3_q, c4_q, c5_q;
  logic signed [SW-1:0] u_d, w_d, u_q, w_q;
  logic [EW-1:0]        spt_d, sps_d, spt_q, sps_q;
  logic [LW-1:0]        sl_d, sl_q;
  logic                 ovl_q, res_q, rem_q;
  logic                 pass;

  assign en    = !v6_q || !out_stall_i;
  assign pop_o = en && valid_i;

  // Side test cross products for four corners against both offset copies
  always_comb begin
    logic [EW-1:0]        px, py;
    logic signed [XW-1:0] zone, ex, ey;
    logic signed [VW-1:0] pr1, pr2, vv;
    for (int k = 0; k < 8; k++) begin
      px    = (((k & 3) == 1) || ((k & 3) == 2)) ? item_i.r2 : item_i.r0;
      py    = ((k & 3) >= 2) ? item_i.r3 : item_i.r1;
      zone  = (k < 4) ? -signed'(XW'(item_i.half)) : signed'(XW'(item_i.half));
      ex    = signed'(XW'(px)) - signed'(XW'(item_i.ax)) - (item_i.steep ? zone : '0);
      ey    = signed'(XW'(py)) - signed'(XW'(item_i.ay)) - (item_i.steep ? '0 : zone);
      pr1   = ex * signed'(item_i.dy);
      pr2   = ey * signed'(item_i.dx);
      vv    = pr1 - pr2;
      zf_d[k] = (vv == '0);
      pf_d[k] = !vv[VW-1] && (vv != '0);
    end
  end

  // Slope numerators, box area and divisor
  always_comb begin
    na_d = signed'(item_i.dq) * signed'(item_i.na);
    nb_d = signed'(item_i.dq) * signed'(item_i.nb);
    dn_d = item_i.dp[EW-1];
    dm_d = dn_d ? CW'(-item_i.dp) : CW'(item_i.dp);
    c1_d.overlap   = item_i.overlap;
    c1_d.removable = item_i.removable;
    c1_d.axis      = item_i.axis;
    c1_d.den_zero  = item_i.den_zero;
    c1_d.side_ok   = 1'b0;
    c1_d.sgn_a     = 1'b0;
    c1_d.sgn_b     = 1'b0;
    c1_d.qa        = item_i.qa;
    c1_d.half      = item_i.half;
    c1_d.qlo       = item_i.qlo;
    c1_d.qhi       = item_i.qhi;
    c1_d.s_lo      = item_i.s_lo;
    c1_d.s_hi      = item_i.s_hi;
    c1_d.srect     = ({1'b0, item_i.bh} + EW'(1)) * ({1'b0, item_i.bw} + EW'(1));
  end

  // Side verdict: a corner on the first copy ends the count there
  always_comb begin
    if (|zf_q[3:0]) begin
      any_pos = |pf_q[3:0];
      any_neg = |(~pf_q[3:0] & ~zf_q[3:0]);
    end else begin
      any_pos = |pf_q;
      any_neg = |(~pf_q & ~zf_q);
    end
    c2         = c1_q;
    c2.side_ok = c1_q.axis || (any_pos && any_neg);
    c2.sgn_a   = na_q[PW-1] ^ dn_q;
    c2.sgn_b   = nb_q[PW-1] ^ dn_q;
    mag_a      = na_q[PW-1] ? QW'(-na_q) : QW'(na_q);
    mag_b      = nb_q[PW-1] ? QW'(-nb_q) : QW'(nb_q);
  end

  lrcf_div u_div_a (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mag_a),
    .den_i (dm_q),
    .quo_o (quo_a)
  );

  lrcf_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mag_b),
    .den_i (dm_q),
    .quo_o (quo_b)
  );

  // Secondary coordinates of the line at both ends of the primary span
  always_comb begin
    logic signed [SW-1:0] qa_s, qs_a, qs_b;
    qa_s = signed'(SW'(dc_q[QW-1].qa));
    qs_a = dc_q[QW-1].sgn_a ? -signed'(SW'(quo_a)) : signed'(SW'(quo_a));
    qs_b = dc_q[QW-1].sgn_b ? -signed'(SW'(quo_b)) : signed'(SW'(quo_b));
    u_d  = dc_q[QW-1].den_zero ? qa_s : qa_s - qs_a;
    w_d  = dc_q[QW-1].den_zero ? qa_s : qa_s - qs_b;
  end

  // Secondary span widened by the half band and clipped to the box
  always_comb begin
    logic signed [SW-1:0] mn, mx, tl, th, lo_s, hi_s, h_s;
    mn   = (u_q < w_q) ? u_q : w_q;
    mx   = (u_q > w_q) ? u_q : w_q;
    h_s  = signed'(SW'(c3_q.half));
    lo_s = signed'(SW'(c3_q.qlo));
    hi_s = signed'(SW'(c3_q.qhi));
    tl   = mn - h_s;
    if (tl <= lo_s) begin
      tl = lo_s;
    end
    th = mx + h_s;
    if (th >= hi_s) begin
      th = hi_s;
    end
    if (th <= tl) begin
      th = tl;
    end
    spt_d = EW'(th - tl);
    sps_d = c3_q.s_hi - c3_q.s_lo;
  end

  // Clipped band area
  assign sl_d = ({1'b0, spt_q} + (EW + 1)'(1)) * ({1'b0, sps_q} + (EW + 1)'(1));

  // Covered share against the rate
  always_comb begin
    logic [TW-1:0] lhs, rhs;
    lhs  = (TW'(sl_q) << 8) - TW'(sl_q);
    rhs  = TW'(kill_rate_i) * TW'(c5_q.srect);
    pass = lhs >= rhs;
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int k = 0; k < QW; k++) begin
        dv_q[k] <= 1'b0;
      end
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      dv_q[0] <= v1_q;
      for (int k = 1; k < QW; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      v3_q <= dv_q[QW-1];
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= c1_d;
      zf_q <= zf_d;
      pf_q <= pf_d;
      na_q <= na_d;
      nb_q <= nb_d;
      dm_q <= dm_d;
      dn_q <= dn_d;
      dc_q[0] <= c2;
      for (int k = 1; k < QW; k++) begin
        dc_q[k] <= dc_q[k-1];
      end
      c3_q  <= dc_q[QW-1];
      u_q   <= u_d;
      w_q   <= w_d;
      c4_q  <= c3_q;
      spt_q <= spt_d;
      sps_q <= sps_d;
      c5_q  <= c4_q;
      sl_q  <= sl_d;
      ovl_q <= c5_q.overlap;
      res_q <= c5_q.overlap && c5_q.side_ok && pass;
      rem_q <= c5_q.overlap && c5_q.side_ok && pass && c5_q.removable;
    end
  end

  assign out_valid_o    = v6_q;
  assign box_overlaps_o = ovl_q;
  assign is_residue_o   = res_q;
  assign remove_box_o   = rem_q;

endmodule
